[src/dbwu_pkg.sv]
// Shared types and codes for the debug breakpoint and watchpoint unit.
`default_nettype none
package dbwu_pkg;

	typedef enum logic [3:0] {
		CMD_ADD_BP = 4'd0,
		CMD_DEL_BP = 4'd1,
		CMD_ADD_WP = 4'd2,
		CMD_DEL_WP = 4'd3,
		CMD_FETCH  = 4'd4,
		CMD_ACCESS = 4'd5,
		CMD_RUN    = 4'd6,
		CMD_CONT   = 4'd7,
		CMD_STEP   = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE        = 3'd0,
		ST_FULL        = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_BP_HIT      = 3'd3,
		ST_WP_HIT      = 3'd4,
		ST_NOT_STARTED = 3'd5,
		ST_HALTED      = 3'd6
	} status_t;

	typedef struct packed {
		logic add;
		logic del;
	} tbl_req_t;

	typedef struct packed {
		logic       free_found;
		logic [3:0] free_slot;
		logic       match_found;
		logic [3:0] match_slot;
	} tbl_rsp_t;

endpackage
`default_nettype wire

[src/dbwu_cmd_if.sv]
// Command channel: valid/ready handshake with command and address.
`default_nettype none
interface dbwu_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [31:0] address;

	modport source (output valid, output command, output address, input ready);
	modport sink (input valid, input command, input address, output ready);
endinterface
`default_nettype wire

[src/dbwu_rsp_if.sv]
// Result channel: valid/ready handshake with status, slot, execute, core_running.
`default_nettype none
interface dbwu_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] slot;
	logic       execute;
	logic       core_running;

	modport source (output valid, output status, output slot, output execute,
		output core_running, input ready);
	modport sink (input valid, input status, input slot, input execute,
		input core_running, output ready);
endinterface
`default_nettype wire

[src/debug_breakpoint_watchpoint_unit_top.sv]
// Top level of the debug breakpoint and watchpoint unit.
//
//   channel | modport | payload                                 | handshake
//   cmd     | sink    | command[3:0], address[31:0]             | valid/ready
//   rsp     | source  | status[2:0], slot[3:0], execute, running | valid/ready
//
// One transaction per cycle sustained while the result is not stalled; a command
// passes through an input register, then table search and run control into the result
// register. Tables and run flags update at the edge that loads the result.
// Reset clears valid bits, run-control flags and both valid stages.
// A stalled result holds and the input register fills, then ready drops.
`default_nettype none
module debug_breakpoint_watchpoint_unit_top #(
	parameter int BP_SLOTS = 16,
	parameter int WP_SLOTS = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	dbwu_cmd_if.sink   cmd,
	dbwu_rsp_if.source rsp
);

	logic        valid_s1;
	logic [3:0]  cmd_s1;
	logic [31:0] addr_s1;

	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [3:0]  slot_q;
	logic        execute_q;
	logic        running_q;

	logic run_q, started_q, step_q, skip_q;
	logic run_d, started_d, step_d, skip_d;

	logic                advance;
	logic                fire;
	dbwu_pkg::tbl_req_t  bp_req, wp_req;
	dbwu_pkg::tbl_rsp_t  bp_rsp, wp_rsp;
	dbwu_pkg::status_t   status_d;
	logic [3:0]          slot_d;
	logic                execute_d;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1  <= cmd.command;
			addr_s1 <= cmd.address;
		end
	end

	assign bp_req.add = fire && (cmd_s1 == dbwu_pkg::CMD_ADD_BP);
	assign bp_req.del = fire && (cmd_s1 == dbwu_pkg::CMD_DEL_BP);
	assign wp_req.add = fire && (cmd_s1 == dbwu_pkg::CMD_ADD_WP);
	assign wp_req.del = fire && (cmd_s1 == dbwu_pkg::CMD_DEL_WP);

	dbwu_slot_table #(.SLOTS(BP_SLOTS)) u_bp_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (bp_req),
		.address (addr_s1),
		.rsp     (bp_rsp)
	);

	dbwu_slot_table #(.SLOTS(WP_SLOTS)) u_wp_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (wp_req),
		.address (addr_s1),
		.rsp     (wp_rsp)
	);

	always_comb begin
		status_d  = dbwu_pkg::ST_DONE;
		slot_d    = '0;
		execute_d = 1'b0;
		run_d     = run_q;
		started_d = started_q;
		step_d    = step_q;
		skip_d    = skip_q;
		case (cmd_s1)
			dbwu_pkg::CMD_ADD_BP: begin
				if (bp_rsp.free_found) slot_d = bp_rsp.free_slot;
				else status_d = dbwu_pkg::ST_FULL;
			end
			dbwu_pkg::CMD_ADD_WP: begin
				if (wp_rsp.free_found) slot_d = wp_rsp.free_slot;
				else status_d = dbwu_pkg::ST_FULL;
			end
			dbwu_pkg::CMD_DEL_BP: begin
				if (bp_rsp.match_found) slot_d = bp_rsp.match_slot;
				else status_d = dbwu_pkg::ST_NOT_FOUND;
			end
			dbwu_pkg::CMD_DEL_WP: begin
				if (wp_rsp.match_found) slot_d = wp_rsp.match_slot;
				else status_d = dbwu_pkg::ST_NOT_FOUND;
			end
			dbwu_pkg::CMD_FETCH: begin
				if (!run_q) begin
					status_d = dbwu_pkg::ST_HALTED;
				end else if (!skip_q && bp_rsp.match_found) begin
					run_d    = 1'b0;
					status_d = dbwu_pkg::ST_BP_HIT;
					slot_d   = bp_rsp.match_slot;
				end else begin
					skip_d    = 1'b0;
					execute_d = 1'b1;
					if (step_q) run_d = 1'b0;
				end
			end
			dbwu_pkg::CMD_ACCESS: begin
				if (wp_rsp.match_found) begin
					run_d    = 1'b0;
					status_d = dbwu_pkg::ST_WP_HIT;
					slot_d   = wp_rsp.match_slot;
				end
			end
			dbwu_pkg::CMD_RUN: begin
				run_d = 1'b1;
				if (!started_q) begin
					started_d = 1'b1;
					step_d    = 1'b0;
				end
			end
			dbwu_pkg::CMD_CONT: begin
				if (started_q) begin
					run_d  = 1'b1;
					skip_d = 1'b1;
					step_d = 1'b0;
				end else begin
					status_d = dbwu_pkg::ST_NOT_STARTED;
				end
			end
			dbwu_pkg::CMD_STEP: begin
				run_d  = 1'b1;
				step_d = 1'b1;
				skip_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			started_q   <= 1'b0;
			step_q      <= 1'b0;
			skip_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (fire) begin
				run_q     <= run_d;
				started_q <= started_d;
				step_q    <= step_d;
				skip_q    <= skip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_d;
			slot_q    <= slot_d;
			execute_q <= execute_d;
			running_q <= run_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.slot         = slot_q;
	assign rsp.execute      = execute_q;
	assign rsp.core_running = running_q;

endmodule
`default_nettype wire

[src/dbwu_slot_table.sv]
// Address table with valid bits, lowest-free and lowest-match priority search.
`default_nettype none
module dbwu_slot_table #(
	parameter int SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dbwu_pkg::tbl_req_t req,
	input  wire logic [31:0]        address,
	output dbwu_pkg::tbl_rsp_t      rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [31:0]      addr_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [IW-1:0]    free_idx;
	logic [IW-1:0]    match_idx;
	logic             free_found;
	logic             match_found;

	always_comb begin
		free_found  = 1'b0;
		free_idx    = '0;
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (valid_q[i] && (addr_q[i] == address)) begin
				match_found = 1'b1;
				match_idx   = IW'(i);
			end
		end
	end

	assign rsp.free_found  = free_found;
	assign rsp.free_slot   = 4'(free_idx);
	assign rsp.match_found = match_found;
	assign rsp.match_slot  = 4'(match_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (req.add && free_found) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (req.del && match_found) begin
				valid_q[match_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.add && free_found) begin
			addr_q[free_idx] <= address;
		end
	end

endmodule
`default_nettype wire

[src/dbwu_checker.sv]
// Port checker for the debug breakpoint and watchpoint unit, with its bind.
`default_nettype none
module dbwu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [2:0] status,
	input wire logic [3:0] slot,
	input wire logic       execute,
	input wire logic       core_running
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(execute) && $stable(core_running))
		else $error("result changed while stalled");

	a_hit_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == dbwu_pkg::ST_BP_HIT || status == dbwu_pkg::ST_WP_HIT)
			|-> !core_running)
		else $error("hit left core running");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && execute |-> status == dbwu_pkg::ST_DONE)
		else $error("execute with non-done status");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == dbwu_pkg::ST_FULL || status == dbwu_pkg::ST_NOT_FOUND
			|| status == dbwu_pkg::ST_HALTED || status == dbwu_pkg::ST_NOT_STARTED)
			|-> slot == 4'd0 && !execute)
		else $error("failed transaction carries slot or execute");

endmodule

bind debug_breakpoint_watchpoint_unit_top dbwu_checker u_dbwu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.slot         (rsp.slot),
	.execute      (rsp.execute),
	.core_running (rsp.core_running)
);
`default_nettype wire
